/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// cond must never be true at a clock edge out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

/* rtl/core/slef_pkg.sv */
// ----------------------------------------------------------------------------
// slef_pkg
// Shared types and constants of the scanline lane edge finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slef_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned LEFT_W   = 10;
  localparam int unsigned RIGHT_W  = 11;
  localparam int unsigned CENTER_W = 10;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CENTER_W-1:0] CENTER_RESET   = 10'd320;
  localparam logic [RIGHT_W-1:0]  NO_RIGHT_RESET = 11'd640;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COLUMN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_RIGHT_VALUE = 1'd1;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             line_end;
  } in_word_t;

  typedef struct packed {
    logic [LEFT_W-1:0]  left_position;
    logic [RIGHT_W-1:0] right_position;
  } out_word_t;

  typedef struct packed {
    logic [CENTER_W-1:0] center_column;
    logic [RIGHT_W-1:0]  no_right_value;
  } cfg_t;

endpackage

/* rtl/core/scanline_lane_edge_finder_core.sv */
// ----------------------------------------------------------------------------
// scanline_lane_edge_finder_core
// Lane edge finder over a binarized scanline stream.
// ----------------------------------------------------------------------------
// One pixel word is taken per clock, back to back, while the input is not
// stalled. An input register feeds the run tracker, whose per-pixel update
// is combinational into its state registers, and the line result is held in
// an output register: the result word of a line is loaded into it when its
// line-end pixel moves on from the input register, which holds that pixel
// while an unread result waits. Only the line-end pixel produces a word; input stalls only when
// a line-end pixel is waiting behind an unread result. Columns saturate at
// MAX_WIDTH-1. Configuration writes take effect at once and are to be made
// while no line is in flight.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scanline_lane_edge_finder_core
  import slef_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_word_t            out_word_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  cfg_t      cfg_q;
  logic      s1_valid_q;
  in_word_t  s1_q;
  logic      s1_adv, step, load_out;
  out_word_t result;
  logic      out_valid_q;
  out_word_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_column  <= CENTER_RESET;
      cfg_q.no_right_value <= NO_RIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CENTER_COLUMN:  cfg_q.center_column  <= cfg_data_i[CENTER_W-1:0];
        CFG_NO_RIGHT_VALUE: cfg_q.no_right_value <= cfg_data_i[RIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // a line-end word may only move on when the output register is free or being read
  assign s1_adv     = !s1_q.line_end || !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && s1_adv;
  assign load_out   = step && s1_q.line_end;
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_word_i;
    end
  end

  slef_run_tracker #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .pix_i    (s1_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `ASSERT_CLK(a_out_from_line_end, $rose(out_valid_q) |-> $past(s1_valid_q && s1_q.line_end), "result word without line end")
  `ASSERT_CLK(a_stall_cause, !in_ready_o |-> s1_valid_q && s1_q.line_end && out_valid_q && !out_ready_i, "input stalled without a blocked result")
  `ASSERT_CLK(a_s1_holds, s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_q), "stalled input register changed")

endmodule

/* rtl/core/slef_run_tracker.sv */
// ----------------------------------------------------------------------------
// slef_run_tracker
// Per-line run tracking: column counter, open run, best left/right centroids.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slef_run_tracker
  import slef_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_word_t  pix_i,
  input  cfg_t      cfg_i,
  output out_word_t result_o
);

  localparam int unsigned IDX_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned SUM_W = (IDX_W + 1 > CENTER_W + 2) ? IDX_W + 1 : CENTER_W + 2;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_WIDTH - 1);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic             inside_q, inside_d;
  logic [IDX_W-1:0] start_q, start_d;
  logic             have_left_q, have_left_d;
  logic [IDX_W-1:0] best_left_q, best_left_d;
  logic             have_right_q, have_right_d;
  logic [IDX_W-1:0] best_right_q, best_right_d;

  logic             fg, last, open_run, close_run, is_right;
  logic [IDX_W-1:0] run_first, run_last, mid;
  logic [SUM_W-1:0] sum, thresh;
  logic             hl_n, hr_n;
  logic [IDX_W-1:0] bl_n, br_n;
  logic [IDX_W+RIGHT_W:0] left_wide, right_wide;

  always_comb begin
    fg        = |pix_i.pixel_value;
    last      = pix_i.line_end;
    open_run  = inside_q || fg;
    run_first = inside_q ? start_q : idx_q;
    close_run = open_run && (!fg || last);

    // end column never falls before the start, even at a saturated index
    if (fg) begin
      run_last = idx_q;
    end else if (idx_q > run_first) begin
      run_last = idx_q - 1'b1;
    end else begin
      run_last = run_first;
    end

    sum      = SUM_W'(run_first) + SUM_W'(run_last);
    mid      = sum[IDX_W:1];
    thresh   = SUM_W'({cfg_i.center_column, 1'b0}) + SUM_W'(2);
    is_right = sum >= thresh;

    hl_n = have_left_q;
    bl_n = best_left_q;
    hr_n = have_right_q;
    br_n = best_right_q;
    if (close_run) begin
      if (is_right) begin
        if (!have_right_q || mid < best_right_q) begin
          hr_n = 1'b1;
          br_n = mid;
        end
      end else begin
        if (!have_left_q || mid > best_left_q) begin
          hl_n = 1'b1;
          bl_n = mid;
        end
      end
    end

    left_wide  = (IDX_W + RIGHT_W + 1)'(hl_n ? bl_n : '0);
    right_wide = hr_n ? (IDX_W + RIGHT_W + 1)'(br_n)
                      : (IDX_W + RIGHT_W + 1)'(cfg_i.no_right_value);
    result_o.left_position  = left_wide[LEFT_W-1:0];
    result_o.right_position = right_wide[RIGHT_W-1:0];

    idx_d        = idx_q;
    inside_d     = inside_q;
    start_d      = start_q;
    have_left_d  = have_left_q;
    best_left_d  = best_left_q;
    have_right_d = have_right_q;
    best_right_d = best_right_q;
    if (step_i) begin
      if (last) begin
        idx_d        = '0;
        inside_d     = 1'b0;
        start_d      = '0;
        have_left_d  = 1'b0;
        best_left_d  = '0;
        have_right_d = 1'b0;
        best_right_d = '0;
      end else begin
        if (idx_q != IDX_MAX) begin
          idx_d = idx_q + 1'b1;
        end
        inside_d     = open_run && !close_run;
        start_d      = run_first;
        have_left_d  = hl_n;
        best_left_d  = bl_n;
        have_right_d = hr_n;
        best_right_d = br_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      inside_q     <= 1'b0;
      start_q      <= '0;
      have_left_q  <= 1'b0;
      best_left_q  <= '0;
      have_right_q <= 1'b0;
      best_right_q <= '0;
    end else begin
      idx_q        <= idx_d;
      inside_q     <= inside_d;
      start_q      <= start_d;
      have_left_q  <= have_left_d;
      best_left_q  <= best_left_d;
      have_right_q <= have_right_d;
      best_right_q <= best_right_d;
    end
  end

  `ASSERT_CLK(a_line_end_clears, step_i && pix_i.line_end |=> idx_q == '0 && !inside_q && !have_left_q && !have_right_q, "line end did not clear tracker")
  `ASSERT_NEVER(a_start_after_idx, inside_q && start_q > idx_q, "open run starts after current column")
  `ASSERT_NEVER(a_left_beyond_idx, have_left_q && best_left_q > idx_q, "left centroid beyond current column")

endmodule
